FILE: hdl/header_framed_crc8_packet_checker_defines.svh
// assertion macros used by the checker file
`ifndef HEADER_FRAMED_CRC8_PACKET_CHECKER_DEFINES_SVH
`define HEADER_FRAMED_CRC8_PACKET_CHECKER_DEFINES_SVH

// implication checked in the same cycle, quiet during reset
`define HFCPC_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

// implication checked in the next cycle, quiet during reset
`define HFCPC_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

// implication checked in the next cycle, also through reset
`define HFCPC_ASSERT_NXT_ANY(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication across reset");

`endif

FILE: hdl/hfcpc_pkg.sv
`timescale 1ns / 1ps

package hfcpc_pkg;

   // default longest frame
   localparam int MAX_FRAME_DEF = 32;

   // width wide enough for any frame length or count compare
   localparam int LEN_W = 7;
   localparam int FB_W = 6;
   localparam int CSR_IDX_W = 2;

   // register reset values
   localparam logic [7:0] HEADER_RST = 8'hCC;
   localparam logic [7:0] POLY_RST = 8'hD5;
   localparam logic [FB_W-1:0] FRAME_BYTES_RST = FB_W'(5);

   // shortest frame: header plus crc byte
   localparam logic [LEN_W-1:0] MIN_FRAME = LEN_W'(2);

   // register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_HEADER_VALUE   = 2'd0,
      CSR_CRC_POLYNOMIAL = 2'd1,
      CSR_FRAME_BYTES    = 2'd2
   } csr_index_type;

   // configuration handed to the deframer
   typedef struct packed {
      logic [7:0]      header_value;
      logic [7:0]      crc_polynomial;
      logic [FB_W-1:0] frame_bytes;
   } cfg_type;

   // one byte of msb-first crc-8
   function automatic logic [7:0] crc8_byte(input logic [7:0] acc,
                                            input logic [7:0] data,
                                            input logic [7:0] poly);
      logic [7:0] v;
      v = acc ^ data;
      for (int b = 0; b < 8; b++) begin
         if (v[7]) begin
            v = {v[6:0], 1'b0} ^ poly;
         end else begin
            v = {v[6:0], 1'b0};
         end
      end
      return v;
   endfunction

endpackage

FILE: hdl/header_framed_crc8_packet_checker.sv
// a frame's verdict is loaded from the input register into the result register
// throughput: 1 byte per cycle while no verdict waits on rsp_ready, set by the
// single-byte crc step between the input register and the result register
// reset: synchronous, active high; hunting for the header, registers at defaults
`timescale 1ns / 1ps

module header_framed_crc8_packet_checker
   import hfcpc_pkg::*;
#(
   parameter int MAX_FRAME = MAX_FRAME_DEF
)
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [7:0]           req_rx_byte,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [7:0]           rsp_computed_crc,
   output logic [7:0]           rsp_received_crc,
   output logic                 rsp_crc_match,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [7:0]           csr_wdata
);

   cfg_type cfg;

   // configuration registers
   hfcpc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // frame hunt, crc and result
   hfcpc_deframer #(
      .MAX_FRAME (MAX_FRAME)
   ) u_deframer (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_rx_byte      (req_rx_byte),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_computed_crc (rsp_computed_crc),
      .rsp_received_crc (rsp_received_crc),
      .rsp_crc_match    (rsp_crc_match)
   );

endmodule

FILE: hdl/hfcpc_csr.sv
`timescale 1ns / 1ps

module hfcpc_csr
   import hfcpc_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [7:0]           csr_wdata,
   output cfg_type              cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg = cfg_ff;

   // register write decode, unknown index ignored
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_HEADER_VALUE:   cfg_in.header_value = csr_wdata;
            CSR_CRC_POLYNOMIAL: cfg_in.crc_polynomial = csr_wdata;
            CSR_FRAME_BYTES:    cfg_in.frame_bytes = csr_wdata[FB_W-1:0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.header_value <= HEADER_RST;
         cfg_ff.crc_polynomial <= POLY_RST;
         cfg_ff.frame_bytes <= FRAME_BYTES_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

FILE: hdl/hfcpc_deframer.sv
`timescale 1ns / 1ps

module hfcpc_deframer
   import hfcpc_pkg::*;
#(
   parameter int MAX_FRAME = MAX_FRAME_DEF
)
(
   input  logic       clock,
   input  logic       reset,
   input  cfg_type    cfg,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_rx_byte,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_computed_crc,
   output logic [7:0] rsp_received_crc,
   output logic       rsp_crc_match
);

   localparam int CNT_W = (MAX_FRAME > 2) ? $clog2(MAX_FRAME) : 1;

   // input register
   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;

   // frame state
   logic             in_frame_ff, in_frame_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [7:0]       crc_ff, crc_in;

   // result register
   logic       out_valid_ff, out_valid_in;
   logic [7:0] out_comp_ff, out_comp_in;
   logic [7:0] out_recv_ff, out_recv_in;
   logic       out_match_ff, out_match_in;

   logic             produce;
   logic             consume;
   logic             out_free;
   logic [LEN_W-1:0] eff_len;
   logic [LEN_W-1:0] next_count;
   logic [LEN_W-1:0] fb_ext;

   // clamp the configured length into the legal range
   always_comb begin
      fb_ext = LEN_W'(cfg.frame_bytes);
      if (fb_ext < MIN_FRAME) begin
         eff_len = MIN_FRAME;
      end else if (fb_ext > LEN_W'(MAX_FRAME)) begin
         eff_len = LEN_W'(MAX_FRAME);
      end else begin
         eff_len = fb_ext;
      end
   end

   assign next_count = LEN_W'(count_ff) + LEN_W'(1);
   assign produce = in_valid_ff && in_frame_ff && (next_count >= eff_len);
   assign out_free = !out_valid_ff || rsp_ready;
   assign consume = in_valid_ff && (!produce || out_free);
   assign req_ready = !in_valid_ff || consume;

   // frame tracking and crc update for the buffered item
   always_comb begin
      in_frame_in = in_frame_ff;
      count_in = count_ff;
      crc_in = crc_ff;
      if (consume) begin
         if (!in_frame_ff) begin
            if (in_byte_ff == cfg.header_value) begin
               in_frame_in = 1'b1;
               count_in = CNT_W'(1);
               crc_in = crc8_byte(8'h00, in_byte_ff, cfg.crc_polynomial);
            end
         end else if (produce) begin
            in_frame_in = 1'b0;
            count_in = '0;
            crc_in = 8'h00;
         end else begin
            count_in = next_count[CNT_W-1:0];
            crc_in = crc8_byte(crc_ff, in_byte_ff, cfg.crc_polynomial);
         end
      end
   end

   // result register load and drain
   always_comb begin
      out_valid_in = out_valid_ff && !rsp_ready;
      out_comp_in = out_comp_ff;
      out_recv_in = out_recv_ff;
      out_match_in = out_match_ff;
      if (consume && produce) begin
         out_valid_in = 1'b1;
         out_comp_in = crc_ff;
         out_recv_in = in_byte_ff;
         out_match_in = (crc_ff == in_byte_ff);
      end
   end

   assign in_valid_in = (req_valid && req_ready) || (in_valid_ff && !consume);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         in_frame_ff <= 1'b0;
         count_ff <= '0;
         crc_ff <= 8'h00;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
         in_frame_ff <= in_frame_in;
         count_ff <= count_in;
         crc_ff <= crc_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_byte_ff <= req_rx_byte;
      end
      out_comp_ff <= out_comp_in;
      out_recv_ff <= out_recv_in;
      out_match_ff <= out_match_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_computed_crc = out_comp_ff;
   assign rsp_received_crc = out_recv_ff;
   assign rsp_crc_match = out_match_ff;

endmodule

FILE: hdl/hfcpc_checker.sv
`timescale 1ns / 1ps
`include "header_framed_crc8_packet_checker_defines.svh"

module hfcpc_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_computed_crc,
   input logic [7:0] rsp_received_crc,
   input logic       rsp_crc_match
);

   logic [16:0] rsp_payload;
   logic        crc_equal;
   logic        rsp_stall;

   // result item fields seen as one word
   assign rsp_payload = {rsp_computed_crc, rsp_received_crc, rsp_crc_match};
   assign crc_equal = (rsp_computed_crc == rsp_received_crc);
   assign rsp_stall = rsp_valid && !rsp_ready;

   // match flag agrees with the two crc values
   `HFCPC_ASSERT_IMP(a_match_flag, clock, reset, rsp_valid, rsp_crc_match == crc_equal)

   // a stalled result item holds
   `HFCPC_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_stall, rsp_valid && $stable(rsp_payload))

   // after reset no result waits and a byte can be taken
   `HFCPC_ASSERT_NXT_ANY(a_reset_clear, clock, reset, !rsp_valid && req_ready)

endmodule

bind header_framed_crc8_packet_checker hfcpc_checker u_hfcpc_checker (
   .clock            (clock),
   .reset            (reset),
   .req_ready        (req_ready),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_computed_crc (rsp_computed_crc),
   .rsp_received_crc (rsp_received_crc),
   .rsp_crc_match    (rsp_crc_match)
);

FILE: bench/tb_header_framed_crc8_packet_checker.sv
`timescale 1ns / 1ps

module tb_header_framed_crc8_packet_checker;
   import hfcpc_pkg::*;

   localparam int FRAME_CAP       = MAX_FRAME_DEF;
   localparam int ITEMS_PER_PHASE = 600;
   localparam int SETTLE_CYCLES   = 6;
   localparam int CYCLE_LIMIT     = 400000;

   // index with no register behind it
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;

   // one frame verdict as the block reports it
   typedef struct packed {
      logic [7:0] computed;
      logic [7:0] received;
      logic       match;
   } frame_check_type;

   typedef enum logic [1:0] {
      ROW_BYTE,
      ROW_CSR,
      ROW_DRAIN
   } row_kind_type;

   // one line of the directed table
   typedef struct {
      row_kind_type           kind;
      logic [7:0]             value;
      logic [CSR_IDX_W-1:0]   idx;
      bit                     pinned;
      frame_check_type        want;
   } dir_row_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   logic [7:0]           req_rx_byte = 8'h00;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic [7:0]           rsp_computed_crc;
   logic [7:0]           rsp_received_crc;
   logic                 rsp_crc_match;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = CSR_HEADER_VALUE;
   logic [7:0]           csr_wdata = 8'h00;

   // predictor copy of registers and frame state
   logic [7:0]      cfg_header = HEADER_RST;
   logic [7:0]      cfg_poly = POLY_RST;
   logic [FB_W-1:0] cfg_flen = FRAME_BYTES_RST;
   logic            fr_open = 1'b0;
   logic [FB_W-1:0] fr_count = '0;
   logic [7:0]      fr_crc = 8'h00;

   frame_check_type frame_reports_q[$];
   dir_row_type     dir_table[$];

   // typed expectation for the item being driven
   bit              pin_next = 1'b0;
   frame_check_type pin_value = '0;

   int unsigned send_gap_pct = 0;
   int unsigned rsp_stall_pct = 0;
   int          errors = 0;
   int          bytes_sent = 0;
   int          cycle_count = 0;

   header_framed_crc8_packet_checker #(
      .MAX_FRAME(FRAME_CAP)
   ) dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_rx_byte      (req_rx_byte),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_computed_crc (rsp_computed_crc),
      .rsp_received_crc (rsp_received_crc),
      .rsp_crc_match    (rsp_crc_match),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   always #6 clock = ~clock;

   // bit-serial msb-first crc-8, one data bit fed per shift
   function automatic logic [7:0] crc_update(input logic [7:0] acc, input logic [7:0] data,
                                             input logic [7:0] poly);
      logic [7:0] c;
      logic       fb;
      c = acc;
      for (int i = 7; i >= 0; i--) begin
         fb = c[7] ^ data[i];
         c = {c[6:0], 1'b0} ^ (fb ? poly : 8'h00);
      end
      return c;
   endfunction

   // frame length after clamping to the legal range
   function automatic int frame_len(input logic [FB_W-1:0] flen);
      int n;
      n = int'(flen);
      if (n < 2) n = 2;
      if (n > FRAME_CAP) n = FRAME_CAP;
      return n;
   endfunction

   // advance the frame state by one byte, queue a verdict on the last one
   function automatic void deframe_byte(input logic [7:0] b);
      frame_check_type rpt;
      if (!fr_open) begin
         if (b == cfg_header) begin
            fr_open = 1'b1;
            fr_count = FB_W'(1);
            fr_crc = crc_update(8'h00, b, cfg_poly);
         end
      end else if (int'(fr_count) + 1 >= frame_len(cfg_flen)) begin
         rpt.computed = fr_crc;
         rpt.received = b;
         rpt.match = (fr_crc == b);
         if (pin_next) rpt = pin_value;
         frame_reports_q.push_back(rpt);
         fr_open = 1'b0;
         fr_count = '0;
         fr_crc = 8'h00;
      end else begin
         fr_crc = crc_update(fr_crc, b, cfg_poly);
         fr_count = fr_count + FB_W'(1);
      end
   endfunction

   function automatic dir_row_type mk_row(input row_kind_type kind, input logic [7:0] value,
                                          input logic [CSR_IDX_W-1:0] idx = CSR_HEADER_VALUE,
                                          input bit pinned = 1'b0, input logic [7:0] c = 8'h00,
                                          input logic [7:0] r = 8'h00, input logic m = 1'b0);
      dir_row_type row;
      row.kind = kind;
      row.value = value;
      row.idx = idx;
      row.pinned = pinned;
      row.want.computed = c;
      row.want.received = r;
      row.want.match = m;
      return row;
   endfunction

   // receiver stalls
   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // track accepted writes and bytes, check every accepted verdict
   always @(posedge clock) begin
      frame_check_type got;
      frame_check_type want;
      if (reset) begin
         cfg_header = HEADER_RST;
         cfg_poly = POLY_RST;
         cfg_flen = FRAME_BYTES_RST;
         fr_open = 1'b0;
         fr_count = '0;
         fr_crc = 8'h00;
         frame_reports_q.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_HEADER_VALUE:   cfg_header = csr_wdata;
               CSR_CRC_POLYNOMIAL: cfg_poly = csr_wdata;
               CSR_FRAME_BYTES:    cfg_flen = csr_wdata[FB_W-1:0];
               default: ;
            endcase
         end
         if (req_valid && req_ready) deframe_byte(req_rx_byte);
         if (rsp_valid && rsp_ready) begin
            got.computed = rsp_computed_crc;
            got.received = rsp_received_crc;
            got.match = rsp_crc_match;
            if (frame_reports_q.size() == 0) begin
               errors++;
               $display("%0t: unexpected result, expected none, actual %02h %02h %0b",
                        $time, got.computed, got.received, got.match);
            end else begin
               want = frame_reports_q.pop_front();
               if (got.computed !== want.computed) begin
                  errors++;
                  $display("%0t: computed_crc expected %02h actual %02h",
                           $time, want.computed, got.computed);
               end
               if (got.received !== want.received) begin
                  errors++;
                  $display("%0t: received_crc expected %02h actual %02h",
                           $time, want.received, got.received);
               end
               if (got.match !== want.match) begin
                  errors++;
                  $display("%0t: crc_match expected %0b actual %0b",
                           $time, want.match, got.match);
               end
            end
         end
      end
   end

   // present one byte, called and returning at a falling edge
   task automatic send_byte(input logic [7:0] b, input bit pin = 1'b0,
                            input frame_check_type pv = '0);
      while ($urandom_range(99) < send_gap_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      pin_next = pin;
      pin_value = pv;
      req_valid <= 1'b1;
      req_rx_byte <= b;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
      pin_next = 1'b0;
      bytes_sent++;
   endtask

   // leaves csr_valid high, the caller lowers it after the last write
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [7:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
   endtask

   // hold off until every verdict is in and the pipeline has gone quiet
   task automatic wait_drain();
      req_valid <= 1'b0;
      while (frame_reports_q.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   initial begin
      int          n;
      int          r;
      logic [7:0]  crc;
      logic [7:0]  d;

      // defaults, noise before the header, header value as payload
      dir_table.push_back(mk_row(ROW_BYTE, 8'h00));
      dir_table.push_back(mk_row(ROW_BYTE, 8'hCC));
      dir_table.push_back(mk_row(ROW_BYTE, 8'hCC));
      dir_table.push_back(mk_row(ROW_BYTE, 8'hFF));
      dir_table.push_back(mk_row(ROW_BYTE, 8'h5A));
      dir_table.push_back(mk_row(ROW_BYTE, 8'h00));
      // zero polynomial keeps the crc at zero, length below two acts as two
      dir_table.push_back(mk_row(ROW_DRAIN, 8'h00));
      dir_table.push_back(mk_row(ROW_CSR, 8'h00, CSR_CRC_POLYNOMIAL));
      dir_table.push_back(mk_row(ROW_CSR, 8'h00, CSR_FRAME_BYTES));
      dir_table.push_back(mk_row(ROW_CSR, 8'hFF, CSR_HEADER_VALUE));
      dir_table.push_back(mk_row(ROW_BYTE, 8'hFF));
      dir_table.push_back(mk_row(ROW_BYTE, 8'h00, CSR_HEADER_VALUE, 1'b1, 8'h00, 8'h00, 1'b1));
      dir_table.push_back(mk_row(ROW_BYTE, 8'hFF));
      dir_table.push_back(mk_row(ROW_BYTE, 8'hFF, CSR_HEADER_VALUE, 1'b1, 8'h00, 8'hFF, 1'b0));
      // zero header under an all-ones polynomial, length of one
      dir_table.push_back(mk_row(ROW_DRAIN, 8'h00));
      dir_table.push_back(mk_row(ROW_CSR, 8'h01, CSR_FRAME_BYTES));
      dir_table.push_back(mk_row(ROW_CSR, 8'h00, CSR_HEADER_VALUE));
      dir_table.push_back(mk_row(ROW_CSR, 8'hFF, CSR_CRC_POLYNOMIAL));
      dir_table.push_back(mk_row(ROW_BYTE, 8'h00));
      dir_table.push_back(mk_row(ROW_BYTE, 8'hAB, CSR_HEADER_VALUE, 1'b1, 8'h00, 8'hAB, 1'b0));
      dir_table.push_back(mk_row(ROW_BYTE, 8'h00));
      dir_table.push_back(mk_row(ROW_BYTE, 8'h00, CSR_HEADER_VALUE, 1'b1, 8'h00, 8'h00, 1'b1));
      // unknown index ignored, then length lowered under an open frame
      dir_table.push_back(mk_row(ROW_DRAIN, 8'h00));
      dir_table.push_back(mk_row(ROW_CSR, 8'h06, CSR_FRAME_BYTES));
      dir_table.push_back(mk_row(ROW_CSR, 8'hCC, CSR_HEADER_VALUE));
      dir_table.push_back(mk_row(ROW_CSR, 8'hD5, CSR_CRC_POLYNOMIAL));
      dir_table.push_back(mk_row(ROW_CSR, 8'hFF, CSR_UNUSED));
      dir_table.push_back(mk_row(ROW_BYTE, 8'hCC));
      dir_table.push_back(mk_row(ROW_BYTE, 8'h11));
      dir_table.push_back(mk_row(ROW_BYTE, 8'h22));
      dir_table.push_back(mk_row(ROW_BYTE, 8'h80));
      dir_table.push_back(mk_row(ROW_DRAIN, 8'h00));
      dir_table.push_back(mk_row(ROW_CSR, 8'h03, CSR_FRAME_BYTES));
      dir_table.push_back(mk_row(ROW_BYTE, 8'h44));

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed part
      send_gap_pct = 31;
      rsp_stall_pct = 72;
      foreach (dir_table[i]) begin
         case (dir_table[i].kind)
            ROW_CSR: write_reg(dir_table[i].idx, dir_table[i].value);
            ROW_DRAIN: begin
               csr_valid <= 1'b0;
               wait_drain();
            end
            default: begin
               csr_valid <= 1'b0;
               send_byte(dir_table[i].value, dir_table[i].pinned, dir_table[i].want);
            end
         endcase
      end

      // random part, three idling mixes
      for (int ph = 0; ph < 3; ph++) begin
         case (ph)
            0: begin
               send_gap_pct = 31;
               rsp_stall_pct = 72;
            end
            1: begin
               send_gap_pct = 72;
               rsp_stall_pct = 31;
            end
            default: begin
               send_gap_pct = 0;
               rsp_stall_pct = 0;
            end
         endcase
         while (bytes_sent < (ph + 1) * ITEMS_PER_PHASE + dir_table.size()) begin
            wait_drain();
            // new settings while idle, extremes now and then
            if ($urandom_range(1) == 0) begin
               r = int'($urandom_range(9));
               d = (r == 0) ? 8'h00 : (r == 1) ? 8'hFF : 8'($urandom_range(255));
               write_reg(CSR_HEADER_VALUE, d);
            end
            if ($urandom_range(1) == 0) begin
               r = int'($urandom_range(9));
               d = (r == 0) ? 8'h00 : (r == 1) ? 8'hFF : 8'($urandom_range(255));
               write_reg(CSR_CRC_POLYNOMIAL, d);
            end
            if ($urandom_range(1) == 0) begin
               r = int'($urandom_range(19));
               if (r == 0) begin
                  case ($urandom_range(6))
                     0: d = 8'h00;
                     1: d = 8'h01;
                     2: d = 8'h21;
                     3: d = 8'h3F;
                     4: d = 8'hFF;
                     5: d = 8'h41;
                     default: d = 8'h20;
                  endcase
               end else if (r == 1) begin
                  d = 8'h20;
               end else begin
                  d = 8'($urandom_range(9, 2));
               end
               write_reg(CSR_FRAME_BYTES, d);
            end
            if ($urandom_range(7) == 0) write_reg(CSR_UNUSED, 8'($urandom_range(255)));
            csr_valid <= 1'b0;

            repeat ($urandom_range(10, 4)) begin
               n = frame_len(cfg_flen);
               r = int'($urandom_range(99));
               if (r < 78) begin
                  // well-formed frame, crc byte right most of the time
                  crc = crc_update(8'h00, cfg_header, cfg_poly);
                  send_byte(cfg_header);
                  for (int k = 2; k < n; k++) begin
                     d = 8'($urandom_range(255));
                     crc = crc_update(crc, d, cfg_poly);
                     send_byte(d);
                  end
                  send_byte(($urandom_range(99) < 60) ? crc : 8'($urandom_range(255)));
               end else if (r < 90) begin
                  // line noise
                  repeat ($urandom_range(4, 1)) send_byte(8'($urandom_range(255)));
               end else begin
                  // frame cut short
                  send_byte(cfg_header);
                  repeat ($urandom_range(n - 2, 0)) send_byte(8'($urandom_range(255)));
               end
            end
         end
      end

      wait_drain();
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (errors == 0 && frame_reports_q.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

FILE: filelist.f
+incdir+hdl
hdl/hfcpc_pkg.sv
hdl/hfcpc_csr.sv
hdl/hfcpc_deframer.sv
hdl/header_framed_crc8_packet_checker.sv
hdl/hfcpc_checker.sv
bench/tb_header_framed_crc8_packet_checker.sv
